// ===== design/rsi_pkg.sv =====
package rsi_pkg;

  // default parameter values
  localparam int PRICE_WIDTH_DEF = 32;
  localparam int MAX_PERIOD_DEF  = 255;
  localparam int EXTRA_FRAC_DEF  = 16;

  // averages carry this many guard bits above the price
  localparam int AVG_GUARD = 8;

  // period register
  localparam int            CFG_W        = 8;
  localparam logic [CFG_W-1:0] PERIOD_RESET = 8'd14;
  localparam int            PERIOD_MIN   = 2;

  // result format: percent in units of 1/65536
  localparam int RSI_W       = 23;
  localparam int RSI_FRAC    = 16;
  localparam int RSI_PERCENT = 100;
  localparam int RSI_PCT_W   = 7;
  localparam int RSI_MAX     = 6553600;
  localparam int OUT_DW      = ((RSI_W + 7) / 8) * 8;

  // sequencer states
  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_DIFF = 11'b000_0000_0010,
    S_NEG  = 11'b000_0000_0100,
    S_WACC = 11'b000_0000_1000,
    S_MUL  = 11'b000_0001_0000,
    S_MADD = 11'b000_0010_0000,
    S_DIV  = 11'b000_0100_0000,
    S_SUM  = 11'b000_1000_0000,
    S_RMUL = 11'b001_0000_0000,
    S_RDIV = 11'b010_0000_0000,
    S_FIN  = 11'b100_0000_0000
  } rsi_state_t;

endpackage

// ===== design/relative_strength_index_unit.sv =====
// channel | dir | signals                      | content
// in      | in  | in_tvalid/in_tready/in_tdata | closing price, unsigned Q16.16
// out     | out | out_tvalid/out_tready/...    | rsi value, undefined flag in tuser
// cfg     | in  | cfg_valid/cfg_ready/cfg_data | period, restarts the run
//
// a warm-up item takes a difference, a negation for a loss and two accumulates;
// the item ending warm-up divides both sums by the period, and a smoothed item
// multiplies each average by period-1, adds the move and divides by the period;
// both then form the rsi on one shared adder, one multiply or divide bit a cycle.
// reset is synchronous and clears the run; in_tready and cfg_ready are high only
// while idle, and a period request takes precedence over a price.
// a finished result waits in the output register while the next price is taken;
// a further result waits in the finish step until the output register is free.
module relative_strength_index_unit
  import rsi_pkg::*;
#(
  parameter int PRICE_WIDTH     = PRICE_WIDTH_DEF,
  parameter int MAX_PERIOD      = MAX_PERIOD_DEF,
  parameter int EXTRA_FRAC_BITS = EXTRA_FRAC_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((PRICE_WIDTH+7)/8)*8-1:0]     in_tdata,   // close_price
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [OUT_DW-1:0]                    out_tdata,  // rsi_value
  output logic [0:0]                           out_tuser,  // undefined_flag
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_W-1:0]                     cfg_data    // period
);

  localparam int PW     = PRICE_WIDTH;
  localparam int AVG_W  = PRICE_WIDTH + EXTRA_FRAC_BITS + AVG_GUARD;
  localparam int PER_W  = $clog2(MAX_PERIOD + 1);
  localparam int ML_W   = (PER_W > RSI_PCT_W) ? PER_W : RSI_PCT_W;
  localparam int MUL_W  = AVG_W + ML_W;
  localparam int REM_W  = AVG_W + 2;
  localparam int DVS_W  = AVG_W + 1;
  localparam int ALU_W  = MUL_W;
  localparam int SW     = $clog2(AVG_W + 1);
  localparam int CMP_W  = (PER_W > CFG_W) ? PER_W : CFG_W;
  localparam int RSI_SH = RSI_W - RSI_FRAC;

  rsi_state_t           state_r, state_nxt;
  logic [CFG_W-1:0]     per_r, per_nxt;
  logic [PER_W-1:0]     cnt_r, cnt_nxt;
  logic [PW-1:0]        prev_r, prev_nxt;
  logic                 prev_vld_r, prev_vld_nxt;
  logic [AVG_W-1:0]     avg_g_r, avg_g_nxt;
  logic [AVG_W-1:0]     avg_l_r, avg_l_nxt;
  logic [PW-1:0]        x_r, x_nxt;
  logic                 gain_r, gain_nxt;
  logic                 sel_r, sel_nxt;
  logic                 warm_r, warm_nxt;
  logic [MUL_W-1:0]     mul_r, mul_nxt;
  logic [ML_W-1:0]      mlr_r, mlr_nxt;
  logic [AVG_W-1:0]     dq_r, dq_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [SW-1:0]        step_r, step_nxt;
  logic [RSI_W-1:0]     res_rsi_r, res_rsi_nxt;
  logic                 res_flag_r, res_flag_nxt;
  logic [RSI_W-1:0]     out_rsi_r, out_rsi_nxt;
  logic                 out_flag_r, out_flag_nxt;
  logic                 out_vld_r, out_vld_nxt;

  logic [CMP_W-1:0]     per_ext;
  logic [PER_W-1:0]     p_eff;
  logic [ALU_W-1:0]     alu_a, alu_b;
  logic                 alu_sub;
  logic [ALU_W:0]       alu_res;
  logic                 alu_carry;
  logic [AVG_W-1:0]     avg_sel;
  logic [AVG_W-1:0]     x_ext;
  logic [REM_W-1:0]     rem_sh;
  logic [AVG_W-1:0]     div_quo;
  logic [MUL_W-1:0]     mul_new;

  // period clamped to the supported range
  assign per_ext = CMP_W'(per_r);
  always_comb begin
    if (per_ext < CMP_W'(PERIOD_MIN)) begin
      p_eff = PER_W'(PERIOD_MIN);
    end else if (per_ext > CMP_W'(MAX_PERIOD)) begin
      p_eff = PER_W'(MAX_PERIOD);
    end else begin
      p_eff = PER_W'(per_ext);
    end
  end

  // operands seen by the shared adder
  assign avg_sel = sel_r ? avg_l_r : avg_g_r;
  assign x_ext   = ((sel_r ? !gain_r : gain_r)) ? (AVG_W'(x_r) << EXTRA_FRAC_BITS) : '0;
  assign rem_sh  = {rem_r[REM_W-2:0], dq_r[AVG_W-1]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      S_DIFF: begin
        alu_a   = ALU_W'(x_r);
        alu_b   = ALU_W'(prev_r);
        alu_sub = 1'b1;
      end
      S_NEG: begin
        alu_b   = ALU_W'(x_r);
        alu_sub = 1'b1;
      end
      S_WACC: begin
        alu_a = ALU_W'(avg_sel);
        alu_b = ALU_W'(x_ext);
      end
      S_MUL, S_RMUL: begin
        alu_a = mul_r << 1;
        alu_b = mlr_r[ML_W-1] ? ALU_W'(avg_sel) : '0;
      end
      S_MADD: begin
        alu_a = mul_r;
        alu_b = ALU_W'(x_ext);
      end
      S_DIV, S_RDIV: begin
        alu_a   = ALU_W'(rem_sh);
        alu_b   = ALU_W'(dvs_r);
        alu_sub = 1'b1;
      end
      S_SUM: begin
        alu_a = ALU_W'(avg_g_r);
        alu_b = ALU_W'(avg_l_r);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  // shared adder, subtracts through the inverted operand
  assign alu_res   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + (ALU_W + 1)'(alu_sub);
  assign alu_carry = alu_res[ALU_W];
  assign div_quo   = {dq_r[AVG_W-2:0], alu_carry};
  assign mul_new   = alu_res[MUL_W-1:0];

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    per_nxt      = per_r;
    cnt_nxt      = cnt_r;
    prev_nxt     = prev_r;
    prev_vld_nxt = prev_vld_r;
    avg_g_nxt    = avg_g_r;
    avg_l_nxt    = avg_l_r;
    x_nxt        = x_r;
    gain_nxt     = gain_r;
    sel_nxt      = sel_r;
    warm_nxt     = warm_r;
    mul_nxt      = mul_r;
    mlr_nxt      = mlr_r;
    dq_nxt       = dq_r;
    rem_nxt      = rem_r;
    dvs_nxt      = dvs_r;
    step_nxt     = step_r;
    res_rsi_nxt  = res_rsi_r;
    res_flag_nxt = res_flag_r;
    out_rsi_nxt  = out_rsi_r;
    out_flag_nxt = out_flag_r;
    out_vld_nxt  = out_vld_r;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (!prev_vld_r) begin
            prev_nxt     = in_tdata[PW-1:0];
            prev_vld_nxt = 1'b1;
          end else begin
            x_nxt     = in_tdata[PW-1:0];
            state_nxt = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        prev_nxt = x_r;
        x_nxt    = alu_res[PW-1:0];
        gain_nxt = alu_carry;
        sel_nxt  = 1'b0;
        warm_nxt = (cnt_r < p_eff);
        if (!alu_carry) begin
          state_nxt = S_NEG;
        end else if (cnt_r < p_eff) begin
          state_nxt = S_WACC;
        end else begin
          mul_nxt   = '0;
          mlr_nxt   = ML_W'(p_eff - PER_W'(1));
          step_nxt  = SW'(ML_W);
          state_nxt = S_MUL;
        end
      end
      S_NEG: begin
        x_nxt = alu_res[PW-1:0];
        if (warm_r) begin
          state_nxt = S_WACC;
        end else begin
          mul_nxt   = '0;
          mlr_nxt   = ML_W'(p_eff - PER_W'(1));
          step_nxt  = SW'(ML_W);
          state_nxt = S_MUL;
        end
      end
      S_WACC: begin
        if (!sel_r) begin
          avg_g_nxt = alu_res[AVG_W-1:0];
          sel_nxt   = 1'b1;
        end else begin
          avg_l_nxt = alu_res[AVG_W-1:0];
          cnt_nxt   = cnt_r + PER_W'(1);
          if ((cnt_r + PER_W'(1)) < p_eff) begin
            state_nxt = S_IDLE;
          end else begin
            sel_nxt   = 1'b0;
            dq_nxt    = avg_g_r;
            rem_nxt   = '0;
            dvs_nxt   = DVS_W'(p_eff);
            step_nxt  = SW'(AVG_W);
            state_nxt = S_DIV;
          end
        end
      end
      S_MUL: begin
        mul_nxt  = mul_new;
        mlr_nxt  = mlr_r << 1;
        step_nxt = step_r - SW'(1);
        if (step_r == SW'(1)) begin
          state_nxt = S_MADD;
        end
      end
      S_MADD: begin
        dq_nxt    = alu_res[AVG_W-1:0];
        rem_nxt   = '0;
        dvs_nxt   = DVS_W'(p_eff);
        step_nxt  = SW'(AVG_W);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt  = alu_carry ? alu_res[REM_W-1:0] : rem_sh;
        dq_nxt   = div_quo;
        step_nxt = step_r - SW'(1);
        if (step_r == SW'(1)) begin
          if (!sel_r) begin
            avg_g_nxt = div_quo;
            sel_nxt   = 1'b1;
            if (warm_r) begin
              dq_nxt   = avg_l_r;
              rem_nxt  = '0;
              step_nxt = SW'(AVG_W);
            end else begin
              mul_nxt   = '0;
              mlr_nxt   = ML_W'(p_eff - PER_W'(1));
              step_nxt  = SW'(ML_W);
              state_nxt = S_MUL;
            end
          end else begin
            avg_l_nxt = div_quo;
            state_nxt = S_SUM;
          end
        end
      end
      S_SUM: begin
        dvs_nxt = alu_res[DVS_W-1:0];
        sel_nxt = 1'b0;
        if (alu_res[DVS_W-1:0] == '0) begin
          res_rsi_nxt  = '0;
          res_flag_nxt = 1'b1;
          state_nxt    = S_FIN;
        end else begin
          mul_nxt   = '0;
          mlr_nxt   = ML_W'(RSI_PERCENT);
          step_nxt  = SW'(ML_W);
          state_nxt = S_RMUL;
        end
      end
      S_RMUL: begin
        mul_nxt  = mul_new;
        mlr_nxt  = mlr_r << 1;
        step_nxt = step_r - SW'(1);
        if (step_r == SW'(1)) begin
          // dividend is the product scaled by 2^RSI_FRAC; its top part seeds the remainder
          rem_nxt   = REM_W'(mul_new >> RSI_SH);
          dq_nxt    = {mul_new[RSI_SH-1:0], {RSI_FRAC{1'b0}}, {(AVG_W-RSI_W){1'b0}}};
          step_nxt  = SW'(RSI_W);
          state_nxt = S_RDIV;
        end
      end
      S_RDIV: begin
        rem_nxt  = alu_carry ? alu_res[REM_W-1:0] : rem_sh;
        dq_nxt   = div_quo;
        step_nxt = step_r - SW'(1);
        if (step_r == SW'(1)) begin
          res_rsi_nxt  = div_quo[RSI_W-1:0];
          res_flag_nxt = 1'b0;
          state_nxt    = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_vld_r || out_tready) begin
          out_rsi_nxt  = res_rsi_r;
          out_flag_nxt = res_flag_r;
          out_vld_nxt  = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a period write restarts the run
    if (cfg_valid && cfg_ready) begin
      per_nxt      = cfg_data;
      cnt_nxt      = '0;
      prev_nxt     = '0;
      prev_vld_nxt = 1'b0;
      avg_g_nxt    = '0;
      avg_l_nxt    = '0;
    end
  end

  // control and run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      per_r      <= PERIOD_RESET;
      cnt_r      <= '0;
      prev_r     <= '0;
      prev_vld_r <= 1'b0;
      avg_g_r    <= '0;
      avg_l_r    <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      per_r      <= per_nxt;
      cnt_r      <= cnt_nxt;
      prev_r     <= prev_nxt;
      prev_vld_r <= prev_vld_nxt;
      avg_g_r    <= avg_g_nxt;
      avg_l_r    <= avg_l_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    gain_r     <= gain_nxt;
    sel_r      <= sel_nxt;
    warm_r     <= warm_nxt;
    mul_r      <= mul_nxt;
    mlr_r      <= mlr_nxt;
    dq_r       <= dq_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    step_r     <= step_nxt;
    res_rsi_r  <= res_rsi_nxt;
    res_flag_r <= res_flag_nxt;
    out_rsi_r  <= out_rsi_nxt;
    out_flag_r <= out_flag_nxt;
  end

  // ports
  assign in_tready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DW'(out_rsi_r);
  assign out_tuser  = out_flag_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= p_eff)
    else $error("warm-up count above period");

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV || state_r == S_RDIV) |-> (rem_r < REM_W'(dvs_r)))
    else $error("divider remainder not below divisor");

  a_rsi_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (res_rsi_r <= RSI_W'(RSI_MAX)))
    else $error("rsi above one hundred percent");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && res_flag_r) |-> (res_rsi_r == '0))
    else $error("undefined result with nonzero value");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the finish step");
`endif

endmodule
